// File: hdl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent implies consequent, consequent may carry a fixed delay
`define ASSERT_IMPLY(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

`endif

// File: hdl/irag_pkg.sv
`timescale 1ns / 1ps

package irag_pkg;

   localparam int unsigned ADDR_W_DEFAULT  = 32;
   localparam int unsigned COORD_W_DEFAULT = 16;

   localparam int unsigned BASE_W      = 32;
   localparam int unsigned FIELD_W     = 16;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned CSR_INDEX_W = 3;

   localparam int unsigned REAL_ROWS_W = 16;
   localparam int unsigned DEST_ROWS_W = 16;
   localparam int unsigned STRIDE_W    = 16;
   localparam int unsigned LANE_PACK_W = 7;
   localparam int unsigned PACK_W      = 5;

   localparam int unsigned PACK_STRIDE_W = PACK_W + STRIDE_W;
   localparam int unsigned ROWS_PACK_W   = REAL_ROWS_W + PACK_W;
   localparam int unsigned ROWS_LANE_W   = DEST_ROWS_W + LANE_PACK_W;

   localparam logic [BASE_W-1:0]      DEST_BASE_RESET     = '0;
   localparam logic [REAL_ROWS_W-1:0] REAL_ROWS_RESET     = 16'd1;
   localparam logic [DEST_ROWS_W-1:0] DEST_ROWS_RESET     = 16'd1;
   localparam logic [STRIDE_W-1:0]    SOURCE_STRIDE_RESET = 16'd1;
   localparam logic [LANE_PACK_W-1:0] LANE_PACK_RESET     = 7'd4;
   localparam logic [PACK_W-1:0]      PACK_WIDTH_RESET    = 5'd4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DEST_BASE     = 3'd0,
      REG_REAL_ROWS     = 3'd1,
      REG_DEST_ROWS     = 3'd2,
      REG_SOURCE_STRIDE = 3'd3,
      REG_LANE_PACK     = 3'd4,
      REG_PACK_WIDTH    = 3'd5
   } csr_reg_type;

   // settings as the datapath sees them: divisors forced nonzero, products ready
   typedef struct packed {
      logic [BASE_W-1:0]        dest_base;
      logic [PACK_W-1:0]        pack;
      logic [LANE_PACK_W-1:0]   lane;
      logic [DEST_ROWS_W-1:0]   dest_rows;
      logic [PACK_STRIDE_W-1:0] pack_stride;
      logic [ROWS_PACK_W-1:0]   rows_pack;
      logic [ROWS_LANE_W-1:0]   rows_lane;
   } cfg_type;

endpackage

// File: hdl/irag_cfg_regs.sv
`timescale 1ns / 1ps

module irag_cfg_regs (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [irag_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [irag_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output irag_pkg::cfg_type                     cfg
);

   localparam int unsigned BW  = irag_pkg::BASE_W;
   localparam int unsigned RRW = irag_pkg::REAL_ROWS_W;
   localparam int unsigned DRW = irag_pkg::DEST_ROWS_W;
   localparam int unsigned SW  = irag_pkg::STRIDE_W;
   localparam int unsigned LW  = irag_pkg::LANE_PACK_W;
   localparam int unsigned PW  = irag_pkg::PACK_W;
   localparam int unsigned PSW = irag_pkg::PACK_STRIDE_W;
   localparam int unsigned RPW = irag_pkg::ROWS_PACK_W;
   localparam int unsigned RLW = irag_pkg::ROWS_LANE_W;

   logic [BW-1:0]  dest_base_ff;
   logic [RRW-1:0] real_rows_ff;
   logic [DRW-1:0] dest_rows_ff;
   logic [SW-1:0]  stride_ff;
   logic [LW-1:0]  lane_pack_ff;
   logic [PW-1:0]  pack_width_ff;

   logic [PSW-1:0] pack_stride_ff, pack_stride_in;
   logic [RPW-1:0] rows_pack_ff, rows_pack_in;
   logic [RLW-1:0] rows_lane_ff, rows_lane_in;

   logic [PW-1:0]  pack_eff;
   logic [LW-1:0]  lane_eff;
   logic [DRW-1:0] rows_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_base_ff  <= irag_pkg::DEST_BASE_RESET;
         real_rows_ff  <= irag_pkg::REAL_ROWS_RESET;
         dest_rows_ff  <= irag_pkg::DEST_ROWS_RESET;
         stride_ff     <= irag_pkg::SOURCE_STRIDE_RESET;
         lane_pack_ff  <= irag_pkg::LANE_PACK_RESET;
         pack_width_ff <= irag_pkg::PACK_WIDTH_RESET;
      end else if (csr_write) begin
         case (irag_pkg::csr_reg_type'(csr_index))
            irag_pkg::REG_DEST_BASE:     dest_base_ff  <= csr_wdata[BW-1:0];
            irag_pkg::REG_REAL_ROWS:     real_rows_ff  <= csr_wdata[RRW-1:0];
            irag_pkg::REG_DEST_ROWS:     dest_rows_ff  <= csr_wdata[DRW-1:0];
            irag_pkg::REG_SOURCE_STRIDE: stride_ff     <= csr_wdata[SW-1:0];
            irag_pkg::REG_LANE_PACK:     lane_pack_ff  <= csr_wdata[LW-1:0];
            irag_pkg::REG_PACK_WIDTH:    pack_width_ff <= csr_wdata[PW-1:0];
            default: begin
            end
         endcase
      end
   end

   // a zero divisor acts as one
   assign pack_eff = (pack_width_ff == '0) ? PW'(1)  : pack_width_ff;
   assign lane_eff = (lane_pack_ff == '0)  ? LW'(1)  : lane_pack_ff;
   assign rows_eff = (dest_rows_ff == '0)  ? DRW'(1) : dest_rows_ff;

   assign pack_stride_in = PSW'(pack_eff) * PSW'(stride_ff);
   assign rows_pack_in   = RPW'(real_rows_ff) * RPW'(pack_eff);
   assign rows_lane_in   = RLW'(rows_eff) * RLW'(lane_eff);

   // products are registered from the settings registers
   always_ff @(posedge clock) begin
      pack_stride_ff <= pack_stride_in;
      rows_pack_ff   <= rows_pack_in;
      rows_lane_ff   <= rows_lane_in;
   end

   always_comb begin
      cfg.dest_base   = dest_base_ff;
      cfg.pack        = pack_eff;
      cfg.lane        = lane_eff;
      cfg.dest_rows   = rows_eff;
      cfg.pack_stride = pack_stride_ff;
      cfg.rows_pack   = rows_pack_ff;
      cfg.rows_lane   = rows_lane_ff;
   end

endmodule

// File: hdl/irag_div_pipe.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// restoring divider, one quotient bit per stage, a word enters every cycle
module irag_div_pipe #(
   parameter int unsigned NUM_WIDTH = 17,
   parameter int unsigned DEN_WIDTH = 16,
   parameter int unsigned TAG_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [NUM_WIDTH-1:0] in_dividend,
   input  logic [TAG_WIDTH-1:0] in_tag,
   input  logic [DEN_WIDTH-1:0] divisor,
   output logic                 out_valid,
   output logic [NUM_WIDTH-1:0] out_quotient,
   output logic [DEN_WIDTH-1:0] out_remainder,
   output logic [TAG_WIDTH-1:0] out_tag
);

   localparam int unsigned N = NUM_WIDTH;

   logic                 vld_ff [N];
   logic [DEN_WIDTH-1:0] rem_ff [N];
   logic [N-1:0]         quo_ff [N];
   logic [N-1:0]         num_ff [N];
   logic [TAG_WIDTH-1:0] tag_ff [N];

   logic                 vld_src [N];
   logic [DEN_WIDTH-1:0] rem_src [N];
   logic [N-1:0]         quo_src [N];
   logic [N-1:0]         num_src [N];
   logic [TAG_WIDTH-1:0] tag_src [N];

   logic [DEN_WIDTH-1:0] rem_in [N];
   logic [N-1:0]         quo_in [N];

   logic [DEN_WIDTH:0]   trial [N];
   logic                 fits  [N];

   always_comb begin
      vld_src[0] = in_valid;
      rem_src[0] = '0;
      quo_src[0] = '0;
      num_src[0] = in_dividend;
      tag_src[0] = in_tag;
      for (int s = 1; s < N; s++) begin
         vld_src[s] = vld_ff[s-1];
         rem_src[s] = rem_ff[s-1];
         quo_src[s] = quo_ff[s-1];
         num_src[s] = num_ff[s-1];
         tag_src[s] = tag_ff[s-1];
      end
      for (int s = 0; s < N; s++) begin
         trial[s] = {rem_src[s], num_src[s][N-1-s]};
         fits[s]  = (trial[s] >= {1'b0, divisor});
         rem_in[s] = fits[s] ? DEN_WIDTH'(trial[s] - {1'b0, divisor})
                             : DEN_WIDTH'(trial[s]);
         quo_in[s] = quo_src[s];
         quo_in[s][N-1-s] = fits[s];
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < N; s++) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_src[s];
         end
         rem_ff[s] <= rem_in[s];
         quo_ff[s] <= quo_in[s];
         num_ff[s] <= num_src[s];
         tag_ff[s] <= tag_src[s];
      end
   end

   assign out_valid     = vld_ff[N-1];
   assign out_quotient  = quo_ff[N-1];
   assign out_remainder = rem_ff[N-1];
   assign out_tag       = tag_ff[N-1];

   `ASSERT_IMPLY(a_rem_below_divisor, clock, reset, out_valid, out_remainder < divisor, "remainder not below divisor")

endmodule

// File: hdl/im2col_repack_address_generator.sv
`timescale 1ns / 1ps
// pipeline: the result strobe follows the start edge through these stages:
//   COORD_WIDTH+1 divider stages, one multiply stage, two add stages
// throughput: one word per cycle, set by the bit-per-stage divider pipelines
// reset: synchronous, clears all valid bits and restores the register defaults; busy is high
//   only during reset, and the receiver cannot stall the result strobe
`include "assert_macros.svh"

module im2col_repack_address_generator #(
   parameter int unsigned ADDR_WIDTH  = irag_pkg::ADDR_W_DEFAULT,
   parameter int unsigned COORD_WIDTH = irag_pkg::COORD_W_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [irag_pkg::BASE_W-1:0]         req_source_base,
   input  logic [irag_pkg::FIELD_W-1:0]        req_row,
   input  logic [irag_pkg::FIELD_W-1:0]        req_column,
   input  logic [irag_pkg::FIELD_W-1:0]        req_row_offset,
   input  logic [irag_pkg::FIELD_W-1:0]        req_column_offset,
   output logic                                rsp_valid,
   output logic [irag_pkg::BASE_W-1:0]         rsp_source_address,
   output logic [irag_pkg::BASE_W-1:0]         rsp_dest_address,
   input  logic                                csr_write,
   input  logic [irag_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [irag_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int unsigned C       = COORD_WIDTH;
   localparam int unsigned N       = COORD_WIDTH + 1;
   localparam int unsigned LATENCY = COORD_WIDTH + 4;
   localparam int unsigned OUT_W   = irag_pkg::BASE_W;
   localparam int unsigned PW      = irag_pkg::PACK_W;
   localparam int unsigned LW      = irag_pkg::LANE_PACK_W;
   localparam int unsigned DRW     = irag_pkg::DEST_ROWS_W;
   localparam int unsigned YS_W    = ((C > DRW) ? C : DRW) + 1;
   localparam int unsigned PA_W    = C + irag_pkg::PACK_STRIDE_W;
   localparam int unsigned PB_W    = N + irag_pkg::ROWS_PACK_W;
   localparam int unsigned PC_W    = YS_W + LW;
   localparam int unsigned PD_W    = N + irag_pkg::ROWS_LANE_W;

   irag_pkg::cfg_type cfg;

   logic accept;
   logic [C-1:0] x, y, yoff, xoff;

   logic         div_a_valid, div_b_valid, div_c_valid;
   logic [N-1:0] qa, qb, qc;
   logic [PW-1:0]  ra;
   logic [LW-1:0]  rb;
   logic [DRW-1:0] rc;
   logic [OUT_W-1:0] base_d;
   logic [C-1:0]     yoff_d, y_d;

   logic [YS_W-1:0] ysum;
   logic [PA_W-1:0] prod_a;
   logic [PB_W-1:0] prod_b;
   logic [PC_W-1:0] prod_c;
   logic [PD_W-1:0] prod_d;

   logic                  m1_valid_ff;
   logic [ADDR_WIDTH-1:0] a_ff, b_ff, c_ff, d_ff, base_ff;
   logic [PW-1:0]         ra_ff;
   logic [LW-1:0]         rb_ff;

   logic                  m2_valid_ff;
   logic [ADDR_WIDTH-1:0] src_part_ff, src_part_in, dst_part_ff, dst_part_in;
   logic [PW-1:0]         ra2_ff;
   logic [LW-1:0]         rb2_ff;

   logic                  out_valid_ff;
   logic [ADDR_WIDTH-1:0] src_ff, src_in, dst_ff, dst_in;

   irag_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign busy   = reset;
   assign accept = start && !busy;

   assign x    = C'(req_column);
   assign y    = C'(req_row);
   assign yoff = C'(req_row_offset);
   assign xoff = C'(req_column_offset);

   // column within the source pack
   irag_div_pipe #(.NUM_WIDTH(N), .DEN_WIDTH(PW), .TAG_WIDTH(OUT_W)) u_div_src (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept),
      .in_dividend   (N'(x)),
      .in_tag        (req_source_base),
      .divisor       (cfg.pack),
      .out_valid     (div_a_valid),
      .out_quotient  (qa),
      .out_remainder (ra),
      .out_tag       (base_d)
   );

   // destination column split into lane block and lane
   irag_div_pipe #(.NUM_WIDTH(N), .DEN_WIDTH(LW), .TAG_WIDTH(C)) u_div_lane (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept),
      .in_dividend   (N'(x) + N'(xoff)),
      .in_tag        (yoff),
      .divisor       (cfg.lane),
      .out_valid     (div_b_valid),
      .out_quotient  (qb),
      .out_remainder (rb),
      .out_tag       (yoff_d)
   );

   // row wrapped into the destination tile, quotient not needed
   irag_div_pipe #(.NUM_WIDTH(N), .DEN_WIDTH(DRW), .TAG_WIDTH(C)) u_div_row (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept),
      .in_dividend   (N'(y)),
      .in_tag        (y),
      .divisor       (cfg.dest_rows),
      .out_valid     (div_c_valid),
      .out_quotient  (qc),
      .out_remainder (rc),
      .out_tag       (y_d)
   );

   // multiply stage
   assign ysum   = YS_W'(yoff_d) + YS_W'(rc);
   assign prod_a = PA_W'(y_d) * PA_W'(cfg.pack_stride);
   assign prod_b = PB_W'(qa) * PB_W'(cfg.rows_pack);
   assign prod_c = PC_W'(ysum) * PC_W'(cfg.lane);
   assign prod_d = PD_W'(qb) * PD_W'(cfg.rows_lane);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= div_a_valid;
      end
      a_ff    <= ADDR_WIDTH'(prod_a);
      b_ff    <= ADDR_WIDTH'(prod_b);
      c_ff    <= ADDR_WIDTH'(prod_c);
      d_ff    <= ADDR_WIDTH'(prod_d);
      base_ff <= ADDR_WIDTH'(base_d);
      ra_ff   <= ra;
      rb_ff   <= rb;
   end

   // partial sums, all modulo 2^ADDR_WIDTH
   assign src_part_in = base_ff + a_ff + b_ff;
   assign dst_part_in = ADDR_WIDTH'(cfg.dest_base) + c_ff + d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else begin
         m2_valid_ff <= m1_valid_ff;
      end
      src_part_ff <= src_part_in;
      dst_part_ff <= dst_part_in;
      ra2_ff      <= ra_ff;
      rb2_ff      <= rb_ff;
   end

   assign src_in = src_part_ff + ADDR_WIDTH'(ra2_ff);
   assign dst_in = dst_part_ff + ADDR_WIDTH'(rb2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= m2_valid_ff;
      end
      src_ff <= src_in;
      dst_ff <= dst_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_source_address = OUT_W'(src_ff);
   assign rsp_dest_address   = OUT_W'(dst_ff);

   `ASSERT_ALWAYS(a_div_lockstep, clock, reset, (div_a_valid == div_b_valid) && (div_a_valid == div_c_valid), "divider pipelines out of step")
   `ASSERT_ALWAYS(a_row_quotient_bound, clock, reset, !div_c_valid || (qc <= N'(y_d)), "row quotient exceeds row")
   `ASSERT_IMPLY(a_rsp_latency, clock, reset, accept, ##LATENCY rsp_valid, "accepted word gave no result")

endmodule
